// ===== sv/rfba_pkg.sv =====
// ----------------------------------------------------------------------------
// rfba_pkg: shared definitions for the radio frame bit aligner
// Frame geometry, status codes, controller states and the mask tables used
// to find and check the bit offset of a received frame.
// ----------------------------------------------------------------------------
`default_nettype none

package rfba_pkg;

  localparam int FLAG_COUNT = 3;
  localparam int FRAME_LEN  = 2 * FLAG_COUNT + 1;
  localparam int CNT_W      = $clog2(FRAME_LEN + 1);
  localparam int ADDR_W     = $clog2(FRAME_LEN);

  typedef enum logic [2:0] {
    STAT_NONE   = 3'd0,
    STAT_SYNC   = 3'd1,
    STAT_STORED = 3'd2,
    STAT_REJECT = 3'd3,
    STAT_FRAME  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MERGE,
    S_RESP,
    S_EMIT_RD,
    S_EMIT_WR
  } state_t;

  localparam logic [7:0] HUNT_MASK [8] = '{
    8'hE7, 8'h73, 8'h39, 8'h1C, 8'h0E, 8'h07, 8'h03, 8'h01
  };

  localparam logic [7:0] TEST_MASK [8] = '{
    8'h00, 8'h80, 8'hC0, 8'hE0, 8'h70, 8'h38, 8'h9C, 8'hCE
  };

  function automatic logic [3:0] find_offset(input logic [7:0] rx);
    logic [3:0] d;
    d = 4'd0;
    for (int i = 7; i >= 0; i--) begin
      if ((rx & HUNT_MASK[i]) == HUNT_MASK[i]) begin
        d = 4'(i + 1);
      end
    end
    return d;
  endfunction

  function automatic logic [7:0] shift_byte(input logic [7:0] rx, input logic [3:0] d);
    logic [7:0] s;
    s = rx << (d - 4'd1);
    return s;
  endfunction

  function automatic logic [7:0] top_bits(input logic [7:0] rx, input logic [3:0] d);
    logic [7:0] t;
    t = rx >> (4'd9 - d);
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== sv/rfba_ram.sv =====
// ----------------------------------------------------------------------------
// rfba_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rfba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/rf_frame_bit_aligner.sv =====
// ----------------------------------------------------------------------------
// rf_frame_bit_aligner: receive-side bit aligner for radio frames
// Hunts for a sync pattern, then shifts and stores frame bytes in a RAM and
// emits the aligned frame as a run of bytes.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carries one raw byte per transaction. out_valid/out_ready
//   carries result transactions: status, frame byte, byte index and a last
//   mark on the final result caused by an input byte.
//   Every byte gives one result, except the byte that completes a frame,
//   which gives FRAME_LEN results with status "frame byte out".
//   Timing: a hunted or rejected byte goes through the evaluate and respond
//   states; a stored byte also goes through the merge state (one registered
//   RAM read, then the merge write into the previous slot unless the offset
//   is 1). A completing byte then goes through emit read and emit write per
//   frame byte: a registered RAM read, then a load into the output register.
//   The block takes one byte at a time; the next byte is accepted once the
//   previous byte's results are all in the output register.
//   Reset clears the alignment state to hunting; the frame RAM needs no
//   clearing pass, since every slot is written before a frame is emitted.
//   When the receiver stalls, the output register holds its transaction and
//   the controller waits before loading the next result.
// ----------------------------------------------------------------------------
`default_nettype none

module rf_frame_bit_aligner (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [2:0] out_status,
  output logic      [7:0] out_frame_byte,
  output logic      [2:0] out_byte_index,
  output logic            out_last
);

  localparam int FL = rfba_pkg::FRAME_LEN;
  localparam int CW = rfba_pkg::CNT_W;
  localparam int AW = rfba_pkg::ADDR_W;

  rfba_pkg::state_t  state_r, state_nxt;
  logic [3:0]        offset_r, offset_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     emit_idx_r, emit_idx_nxt;
  logic [7:0]        rx_r, rx_nxt;
  rfba_pkg::status_t resp_r, resp_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [2:0] out_status_r, out_status_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic [2:0] out_index_r, out_index_nxt;
  logic       out_last_r, out_last_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic          out_free;
  logic [CW-1:0] count_m1;
  logic [3:0]    hunt_d;
  logic [7:0]    tmask;

  rfba_ram #(
    .WIDTH(8),
    .DEPTH(FL)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign out_free = !out_valid_r || out_ready;
  assign count_m1 = count_r - CW'(1);
  assign hunt_d   = rfba_pkg::find_offset(rx_r);
  assign tmask    = rfba_pkg::TEST_MASK[3'(offset_r - 4'd1)];

  always_comb begin
    state_nxt      = state_r;
    offset_nxt     = offset_r;
    count_nxt      = count_r;
    emit_idx_nxt   = emit_idx_r;
    rx_nxt         = rx_r;
    resp_nxt       = resp_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_byte_nxt   = out_byte_r;
    out_index_nxt  = out_index_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_raddr      = emit_idx_r;
    in_ready       = 1'b0;

    case (state_r)
      rfba_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          rx_nxt    = in_rx_byte;
          state_nxt = rfba_pkg::S_EVAL;
        end
      end
      rfba_pkg::S_EVAL: begin
        if (offset_r == 4'd0) begin
          offset_nxt = hunt_d;
          state_nxt  = rfba_pkg::S_RESP;
          if (hunt_d != 4'd0) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = rfba_pkg::shift_byte(rx_r, hunt_d);
            count_nxt = CW'(1);
            resp_nxt  = rfba_pkg::STAT_SYNC;
          end else begin
            count_nxt = '0;
            resp_nxt  = rfba_pkg::STAT_NONE;
          end
        end else if (count_r == CW'(1) && offset_r != 4'd1 && (rx_r & tmask) != tmask) begin
          count_nxt  = '0;
          offset_nxt = 4'd0;
          resp_nxt   = rfba_pkg::STAT_REJECT;
          state_nxt  = rfba_pkg::S_RESP;
        end else begin
          if (count_r < CW'(FL)) begin
            ram_we    = 1'b1;
            ram_waddr = count_r[AW-1:0];
            ram_wdata = rfba_pkg::shift_byte(rx_r, offset_r);
          end
          ram_raddr = count_m1[AW-1:0];
          state_nxt = rfba_pkg::S_MERGE;
        end
      end
      rfba_pkg::S_MERGE: begin
        if (offset_r != 4'd1) begin
          ram_we    = 1'b1;
          ram_waddr = count_m1[AW-1:0];
          ram_wdata = ram_rdata | rfba_pkg::top_bits(rx_r, offset_r);
        end
        if (count_r == CW'(FL)) begin
          emit_idx_nxt = '0;
          state_nxt    = rfba_pkg::S_EMIT_RD;
        end else begin
          count_nxt = count_r + CW'(1);
          resp_nxt  = rfba_pkg::STAT_STORED;
          state_nxt = rfba_pkg::S_RESP;
        end
      end
      rfba_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = resp_r;
          out_byte_nxt   = '0;
          out_index_nxt  = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = rfba_pkg::S_IDLE;
        end
      end
      rfba_pkg::S_EMIT_RD: begin
        state_nxt = rfba_pkg::S_EMIT_WR;
      end
      rfba_pkg::S_EMIT_WR: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = rfba_pkg::STAT_FRAME;
          out_byte_nxt   = ram_rdata;
          out_index_nxt  = 3'(emit_idx_r);
          out_last_nxt   = (emit_idx_r == AW'(FL - 1));
          if (emit_idx_r == AW'(FL - 1)) begin
            offset_nxt = 4'd0;
            count_nxt  = '0;
            state_nxt  = rfba_pkg::S_IDLE;
          end else begin
            emit_idx_nxt = emit_idx_r + AW'(1);
            state_nxt    = rfba_pkg::S_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = rfba_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rfba_pkg::S_IDLE;
      offset_r    <= 4'd0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      offset_r    <= offset_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    emit_idx_r   <= emit_idx_nxt;
    rx_r         <= rx_nxt;
    resp_r       <= resp_nxt;
    out_status_r <= out_status_nxt;
    out_byte_r   <= out_byte_nxt;
    out_index_r  <= out_index_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_frame_byte = out_byte_r;
  assign out_byte_index = out_index_r;
  assign out_last       = out_last_r;

  a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
    offset_r <= 4'd8)
    else $error("bit offset out of range");

  a_merge_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rfba_pkg::S_MERGE |-> offset_r != 4'd0 && count_r != '0)
    else $error("merge while hunting");

  a_frame_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == rfba_pkg::STAT_FRAME && out_last_r
    |-> out_index_r == 3'(FL - 1))
    else $error("frame ends at wrong index");

  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == rfba_pkg::S_EVAL)
    else $error("accepted byte not evaluated");

endmodule

`default_nettype wire
